[design/lpht_pkg.sv]
// shared types and constants for the linear probing hash table
package lpht_pkg;

   // fixed field widths of the request and response items
   localparam int KEY_WIDTH  = 64;
   localparam int HASH_BITS  = 31;
   localparam int DATA_BITS  = 64;
   localparam int SLOT_BITS  = 6;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // request opcodes
   typedef enum logic [1:0] {
      OP_LOOKUP    = 2'd0,
      OP_INSERT    = 2'd1,
      OP_OVERWRITE = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   // request payload
   typedef struct packed {
      op_type                 opcode;
      logic [KEY_WIDTH-1:0]   key;
      logic [HASH_BITS-1:0]   hash_value;
      logic [DATA_BITS-1:0]   value_in;
   } req_type;

   // response payload
   typedef struct packed {
      logic                   found;
      logic [DATA_BITS-1:0]   value_out;
      logic [SLOT_BITS-1:0]   slot;
      logic                   status;
   } rsp_type;

endpackage

[design/lpht_slot_ram.sv]
// slot memory: one write port, one registered read port
module lpht_slot_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 160
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lpht_hash_mod.sv]
// start slot reduction modulo the table capacity by reciprocal multiplication
module lpht_hash_mod #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lpht_pkg::HASH_BITS-1:0]    hash_value,
   output logic                              done,
   output logic [$clog2(CAPACITY)-1:0]       remainder
);

   localparam int IW    = $clog2(CAPACITY);
   localparam int HB    = lpht_pkg::HASH_BITS;
   localparam int MulBW = HB + 2;
   localparam int ProdW = HB + MulBW;
   localparam int Shift = HB + IW;
   // rounded-up reciprocal gives the exact quotient for every hash value
   localparam logic [63:0]      Recip64 = ((64'd1 << Shift) + 64'(CAPACITY) - 64'd1)
                                          / 64'(CAPACITY);
   localparam logic [MulBW-1:0] RecipB  = MulBW'(Recip64);
   localparam logic [MulBW-1:0] CapB    = MulBW'(CAPACITY);

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_RECIP,
      STEP_BACK,
      STEP_DONE
   } step_type;

   step_type         step_ff, step_in;
   logic [HB-1:0]    hash_ff, hash_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [HB-1:0]    quot;
   logic [HB-1:0]    mul_a;
   logic [MulBW-1:0] mul_b;
   logic [ProdW-1:0] mul_p;

   // shared multiplier: hash times reciprocal, then quotient times capacity
   always_comb begin
      quot  = HB'(prod_ff >> Shift);
      mul_a = (step_ff == STEP_RECIP) ? hash_ff : quot;
      mul_b = (step_ff == STEP_RECIP) ? RecipB : CapB;
      mul_p = ProdW'(mul_a) * ProdW'(mul_b);
   end

   // step sequencing
   always_comb begin
      step_in = step_ff;
      hash_in = hash_ff;
      prod_in = prod_ff;
      if (start) begin
         step_in = STEP_RECIP;
         hash_in = hash_value;
      end else begin
         case (step_ff)
            STEP_RECIP: begin
               prod_in = mul_p;
               step_in = STEP_BACK;
            end
            STEP_BACK: begin
               prod_in = mul_p;
               step_in = STEP_DONE;
            end
            STEP_DONE: begin
               step_in = STEP_IDLE;
            end
            default: begin
               step_in = STEP_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
      hash_ff <= hash_in;
      prod_ff <= prod_in;
   end

   // remainder is below capacity, so the low bits of the difference suffice
   assign done      = (step_ff == STEP_DONE);
   assign remainder = hash_ff[IW-1:0] - prod_ff[IW-1:0];

endmodule

[design/linear_probe_hash_table_core.sv]
// Linear probing hash table: one request in, one response out, slots probed one per cycle.
// Each request probes between 1 and CAPACITY slots; when CAPACITY is not a power of two,
// the start slot is first reduced from the hash by the modulo unit.
// Clear sweeps every slot to unused before its reply. One request at a time;
// the next request is taken when the block returns to idle after handing its result to the response register.
// Reset is synchronous; it is followed by a sweep that empties every slot.
module linear_probe_hash_table_core #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::rsp_type rsp_data
);

   localparam int IW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int SumW    = CW + 1;
   localparam bit CapPow2 = ((CAPACITY & (CAPACITY - 1)) == 0);
   localparam logic [IW-1:0]   IdxLast = IW'(CAPACITY - 1);
   localparam logic [SumW-1:0] CapSum  = SumW'(CAPACITY);
   localparam logic [CW-1:0]   CapCnt  = CW'(CAPACITY);

   // slot entry layout: used, hash, key, value
   localparam int KeyLo   = lpht_pkg::DATA_BITS;
   localparam int HashLo  = KeyLo + KEY_BITS;
   localparam int UsedPos = HashLo + lpht_pkg::HASH_BITS;
   localparam int EntryW  = UsedPos + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_PROBE,
      ST_DELIVER
   } state_type;

   state_type         state_ff, state_in;
   lpht_pkg::req_type req_ff, req_in;
   logic [IW-1:0]     start_ff, start_in;
   logic [IW-1:0]     probe_idx_ff, probe_idx_in;
   logic [IW-1:0]     probe_cnt_ff, probe_cnt_in;
   logic [IW-1:0]     sweep_ff, sweep_in;
   logic [CW-1:0]     count_ff, count_in;
   lpht_pkg::rsp_type result_ff, result_in;
   logic              clr_reply_ff, clr_reply_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [EntryW-1:0] wr_data;
   logic [EntryW-1:0] rd_data;
   logic [EntryW-1:0] new_entry;
   logic              mod_start;
   logic              mod_done;
   logic [IW-1:0]     mod_rem;

   logic                              rd_used;
   logic [lpht_pkg::HASH_BITS-1:0]    rd_hash;
   logic [KEY_BITS-1:0]               rd_key;
   logic [lpht_pkg::DATA_BITS-1:0]    rd_value;
   logic                              hit;
   logic                              empty;
   logic                              last_probe;
   logic [SumW-1:0]                   fill_sum;
   logic                              table_full;

   // slot storage
   lpht_slot_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (EntryW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (probe_idx_in),
      .rd_data (rd_data)
   );

   // start slot for capacities that are not a power of two
   lpht_hash_mod #(
      .CAPACITY (CAPACITY)
   ) u_hash_mod (
      .clock      (clock),
      .reset      (reset),
      .start      (mod_start),
      .hash_value (req_data.hash_value),
      .done       (mod_done),
      .remainder  (mod_rem)
   );

   // unpack the slot read back for the current probe
   always_comb begin
      rd_used  = rd_data[UsedPos];
      rd_hash  = rd_data[UsedPos-1:HashLo];
      rd_key   = rd_data[HashLo-1:KeyLo];
      rd_value = rd_data[lpht_pkg::DATA_BITS-1:0];
      new_entry = {1'b1, req_ff.hash_value, req_ff.key[KEY_BITS-1:0], req_ff.value_in};
   end

   // probe compare and fill test
   always_comb begin
      empty      = !rd_used;
      hit        = rd_used && (rd_hash == req_ff.hash_value)
                   && (rd_key == req_ff.key[KEY_BITS-1:0]);
      last_probe = (probe_cnt_ff == IdxLast);
      fill_sum   = {1'b0, count_ff} + SumW'(count_ff >> 3);
      table_full = (fill_sum >= CapSum);
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      start_in     = start_ff;
      probe_idx_in = probe_idx_ff;
      probe_cnt_in = probe_cnt_ff;
      sweep_in     = sweep_ff;
      count_in     = count_ff;
      result_in    = result_ff;
      clr_reply_in = clr_reply_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mod_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = probe_idx_ff;
      wr_data      = new_entry;

      // response register drains on transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // sweep all slots to unused
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
            if (sweep_ff == IdxLast) begin
               count_in  = '0;
               result_in = '0;
               state_in  = clr_reply_ff ? ST_DELIVER : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         // take a request and pick the start slot, or start the clear sweep
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               probe_cnt_in = '0;
               if (req_data.opcode == lpht_pkg::OP_CLEAR) begin
                  sweep_in     = '0;
                  clr_reply_in = 1'b1;
                  state_in     = ST_CLEAR;
               end else if (CapPow2) begin
                  probe_idx_in = req_data.hash_value[IW-1:0];
                  start_in     = req_data.hash_value[IW-1:0];
                  state_in     = ST_PROBE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end
         end
         // wait for the hash reduction
         ST_MOD: begin
            if (mod_done) begin
               probe_idx_in = mod_rem;
               start_in     = mod_rem;
               state_in     = ST_PROBE;
            end
         end
         // one slot per cycle until a match, an empty slot or a full lap
         ST_PROBE: begin
            if (hit || empty || last_probe) begin
               result_in = '0;
               state_in  = ST_DELIVER;
               if (hit) begin
                  result_in.found     = 1'b1;
                  result_in.value_out = rd_value;
                  result_in.slot      = lpht_pkg::SLOT_BITS'(probe_idx_ff);
                  if (req_ff.opcode == lpht_pkg::OP_OVERWRITE) begin
                     wr_en = 1'b1;
                  end
               end else if (req_ff.opcode == lpht_pkg::OP_LOOKUP) begin
                  result_in.slot = empty ? lpht_pkg::SLOT_BITS'(probe_idx_ff)
                                         : lpht_pkg::SLOT_BITS'(start_ff);
               end else if (!empty || table_full) begin
                  result_in.status = lpht_pkg::STATUS_FULL;
               end else begin
                  wr_en          = 1'b1;
                  count_in       = count_ff + 1'b1;
                  result_in.slot = lpht_pkg::SLOT_BITS'(probe_idx_ff);
                  if (req_ff.opcode == lpht_pkg::OP_INSERT) begin
                     result_in.value_out = req_ff.value_in;
                  end
               end
            end else begin
               probe_idx_in = (probe_idx_ff == IdxLast) ? '0 : probe_idx_ff + 1'b1;
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end
         // hand the result to the response register once it is free
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         clr_reply_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_reply_ff <= clr_reply_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      start_ff     <= start_in;
      probe_idx_ff <= probe_idx_in;
      probe_cnt_ff <= probe_cnt_in;
      result_ff    <= result_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // entry count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCnt)
      else $error("entry count above capacity");

   // refused key reports nothing else
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status) |->
         (!rsp_data_ff.found && (rsp_data_ff.value_out == '0) && (rsp_data_ff.slot == '0)))
      else $error("full status with nonzero result fields");

   // a hit is never refused
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found) |-> (rsp_data_ff.status == lpht_pkg::STATUS_OK))
      else $error("found with full status");

   // slot memory written only while clearing or at the end of a probe
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == ST_CLEAR) || (state_ff == ST_PROBE)))
      else $error("slot write outside clear or probe");

   // a request transfer makes the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after request transfer");
`endif

endmodule

[sim/linear_probe_hash_table_core_test.sv]
// self-checking testbench for the linear probing hash table core
`timescale 1ns / 100ps

module linear_probe_hash_table_core_test;

   localparam int TABLE_SLOTS = 64;
   localparam int SETTLE_CYCLES = 80;      // longest probe chain or clear, plus margin
   localparam int STALL_LIMIT = 3000;      // cycles without any transfer
   localparam int POOL_SIZE = 80;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lpht_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lpht_pkg::rsp_type rsp_data;

   // table contents as the block should hold them
   bit                               table_used [TABLE_SLOTS];
   logic [lpht_pkg::HASH_BITS-1:0]   table_hash [TABLE_SLOTS];
   logic [lpht_pkg::KEY_WIDTH-1:0]   table_key  [TABLE_SLOTS];
   logic [lpht_pkg::DATA_BITS-1:0]   table_data [TABLE_SLOTS];
   int                               table_count = 0;

   lpht_pkg::rsp_type awaited_replies[$];

   // keys reused by the random traffic so that hits and collisions occur
   logic [lpht_pkg::KEY_WIDTH-1:0] pool_key  [POOL_SIZE];
   logic [lpht_pkg::HASH_BITS-1:0] pool_hash [POOL_SIZE];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int req_count = 0;
   int hit_count = 0;
   int refused_count = 0;
   int stored_count = 0;
   int clear_count = 0;

   linear_probe_hash_table_core #(
      .CAPACITY(TABLE_SLOTS),
      .KEY_BITS(lpht_pkg::KEY_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // probe from hash mod capacity, then apply the request to the table copy
   function automatic lpht_pkg::rsp_type probe_and_update(input lpht_pkg::req_type item);
      lpht_pkg::rsp_type res;
      int      idx;
      int      pos;
      bit      stopped;
      bit      hit;
      res = '0;
      if (item.opcode == lpht_pkg::OP_CLEAR) begin
         for (int i = 0; i < TABLE_SLOTS; i++) table_used[i] = 1'b0;
         table_count = 0;
         return res;
      end
      idx = int'(item.hash_value % TABLE_SLOTS);
      pos = idx;
      stopped = 1'b0;
      hit = 1'b0;
      for (int n = 0; n < TABLE_SLOTS && !stopped; n++) begin
         if (!table_used[idx]) begin
            pos = idx;
            stopped = 1'b1;
         end else if (table_hash[idx] == item.hash_value && table_key[idx] == item.key) begin
            pos = idx;
            stopped = 1'b1;
            hit = 1'b1;
         end else begin
            idx = (idx + 1) % TABLE_SLOTS;
         end
      end
      if (hit) begin
         res.found = 1'b1;
         res.slot = lpht_pkg::SLOT_BITS'(pos);
         res.value_out = table_data[pos];
         if (item.opcode == lpht_pkg::OP_OVERWRITE) table_data[pos] = item.value_in;
      end else if (item.opcode == lpht_pkg::OP_LOOKUP) begin
         res.slot = lpht_pkg::SLOT_BITS'(pos);
      end else if (!stopped || table_count + table_count / 8 >= TABLE_SLOTS) begin
         res.status = lpht_pkg::STATUS_FULL;
      end else begin
         table_used[pos] = 1'b1;
         table_hash[pos] = item.hash_value;
         table_key[pos] = item.key;
         table_data[pos] = item.value_in;
         table_count++;
         res.slot = lpht_pkg::SLOT_BITS'(pos);
         res.value_out = (item.opcode == lpht_pkg::OP_INSERT) ? item.value_in : '0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
   endtask

   // predict on each request transfer, check on each response transfer
   always @(posedge clock) begin
      lpht_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = probe_and_update(req_data);
            awaited_replies.push_back(want);
            req_count++;
            if (req_data.opcode == lpht_pkg::OP_CLEAR) clear_count++;
            else if (want.found) hit_count++;
            else if (want.status == lpht_pkg::STATUS_FULL) refused_count++;
            else if (req_data.opcode != lpht_pkg::OP_LOOKUP) stored_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.value_out, '0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 64'(rsp_data.found), 64'(want.found));
               if (rsp_data.value_out !== want.value_out)
                  report_mismatch("value_out", rsp_data.value_out, want.value_out);
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", 64'(rsp_data.slot), 64'(want.slot));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic lpht_pkg::req_type make_req(input lpht_pkg::op_type op,
                                                  input logic [lpht_pkg::KEY_WIDTH-1:0] k,
                                                  input logic [lpht_pkg::HASH_BITS-1:0] h,
                                                  input logic [lpht_pkg::DATA_BITS-1:0] v);
      lpht_pkg::req_type item;
      item.opcode = op;
      item.key = k;
      item.hash_value = h;
      item.value_in = v;
      return item;
   endfunction

   // one request transfer, with random sender gaps ahead of it
   task automatic issue_request(input lpht_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every response is back and the block is quiet
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // field extremes, every opcode, hits, misses, collisions and wrap-around
   task automatic test_basic_operations();
      logic [63:0] ones;
      ones = '1;
      issue_request(make_req(lpht_pkg::OP_CLEAR, ones, '1, ones));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, '0, '0, ones));
      issue_request(make_req(lpht_pkg::OP_INSERT, ones, '1, ones));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, ones, '1, '0));
      issue_request(make_req(lpht_pkg::OP_INSERT, ones, '1, '0));
      issue_request(make_req(lpht_pkg::OP_OVERWRITE, ones, '1, 64'h0123_4567_89ab_cdef));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, ones, '1, ones));
      // same low hash bits, different key: wraps to slot zero
      issue_request(make_req(lpht_pkg::OP_INSERT, '0, 31'd63, 64'h1));
      // same key, different hash: a distinct entry
      issue_request(make_req(lpht_pkg::OP_INSERT, ones, 31'h3f, 64'h2));
      issue_request(make_req(lpht_pkg::OP_OVERWRITE, 64'h5555, '0, 64'h3));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, 64'h7777, 31'd63, '0));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, '0, 31'd63, '0));
      issue_request(make_req(lpht_pkg::OP_INSERT, '0, '0, '0));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, ones, 31'h3f, '0));
      issue_request(make_req(lpht_pkg::OP_CLEAR, 64'hdead_beef, 31'h1234, ones));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, ones, '1, '0));
      issue_request(make_req(lpht_pkg::OP_INSERT, {32{2'b10}}, 31'h2aaa_aaaa, {32{2'b01}}));
      issue_request(make_req(lpht_pkg::OP_INSERT, {32{2'b01}}, 31'h5555_5555, {32{2'b10}}));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, {32{2'b10}}, 31'h2aaa_aaaa, '0));
      issue_request(make_req(lpht_pkg::OP_OVERWRITE, {32{2'b01}}, 31'h5555_5555, ones));
      issue_request(make_req(lpht_pkg::OP_LOOKUP, {32{2'b01}}, 31'h5555_5555, '0));
      wait_for_replies();
   endtask

   // pack one cluster until new keys are refused, then hit the full table
   task automatic test_fill_and_refusal();
      logic [lpht_pkg::KEY_WIDTH-1:0] k;
      logic [lpht_pkg::HASH_BITS-1:0] h;
      logic [lpht_pkg::KEY_WIDTH-1:0] kept_key [4];
      logic [lpht_pkg::HASH_BITS-1:0] kept_hash [4];
      issue_request(make_req(lpht_pkg::OP_CLEAR, '0, '0, '0));
      for (int i = 0; i < 60; i++) begin
         k = {$urandom, $urandom};
         h = {25'($urandom), 6'($urandom_range(60, 63))};
         if (i < 4) begin
            kept_key[i] = k;
            kept_hash[i] = h;
         end
         issue_request(make_req((i % 3 == 0) ? lpht_pkg::OP_OVERWRITE : lpht_pkg::OP_INSERT,
                                k, h, {$urandom, $urandom}));
      end
      issue_request(make_req(lpht_pkg::OP_LOOKUP, {$urandom, $urandom}, 31'd62, '0));
      for (int i = 0; i < 4; i++) begin
         issue_request(make_req(lpht_pkg::OP_LOOKUP, kept_key[i], kept_hash[i], '0));
         issue_request(make_req(i[0] ? lpht_pkg::OP_OVERWRITE : lpht_pkg::OP_INSERT,
                                kept_key[i], kept_hash[i], {$urandom, $urandom}));
      end
      issue_request(make_req(lpht_pkg::OP_INSERT, kept_key[0], kept_hash[0] ^ 31'h4000_0000,
                             '1));
      issue_request(make_req(lpht_pkg::OP_OVERWRITE, {$urandom, $urandom}, 31'($urandom),
                             '1));
      wait_for_replies();
   endtask

   task automatic refresh_key_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_key[i] = (i > 0 && $urandom_range(7) == 0) ? pool_key[i-1] : {$urandom, $urandom};
         pool_hash[i] = 31'($urandom);
         // crowd about half the keys into a few home slots
         if ($urandom_range(1)) pool_hash[i][5:0] = 6'($urandom_range(0, 7));
      end
   endtask

   // random mix over a shared key pool with the given idling
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
      int                             pick;
      int                             sel;
      lpht_pkg::op_type               op;
      logic [lpht_pkg::KEY_WIDTH-1:0] k;
      logic [lpht_pkg::HASH_BITS-1:0] h;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      refresh_key_pool();
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(99);
         sel = $urandom_range(POOL_SIZE - 1);
         k = pool_key[sel];
         h = pool_hash[sel];
         if ($urandom_range(9) == 0) begin
            k = {$urandom, $urandom};
            h = 31'($urandom);
         end
         if ($urandom_range(19) == 0) begin
            pool_key[sel] = {$urandom, $urandom};
            pool_hash[sel] = 31'($urandom);
         end
         if (pick < 2) op = lpht_pkg::OP_CLEAR;
         else if (pick < 37) op = lpht_pkg::OP_LOOKUP;
         else if (pick < 70) op = lpht_pkg::OP_INSERT;
         else op = lpht_pkg::OP_OVERWRITE;
         issue_request(make_req(op, k, h, {$urandom, $urandom}));
      end
      wait_for_replies();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_basic_operations();
      test_fill_and_refusal();
      test_random_traffic(220, 0, 0);
      test_random_traffic(220, 48, 0);
      test_random_traffic(220, 0, 48);
      test_random_traffic(220, 8, 8);
      $display("covered %0d requests: %0d hits, %0d new keys stored, %0d refused, %0d clears",
               req_count, hit_count, stored_count, refused_count, clear_count);
      $display("idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
